// ----- src/txw_pkg.sv -----
`timescale 1ns / 1ps

package txw_pkg;

	localparam int ROW_COUNT_DEF  = 32;
	localparam int ROW_LENGTH_DEF = 128;

	localparam logic [6:0] WRAP_WIDTH_RESET = 7'd80;
	localparam int         MIN_WIDTH        = 4;
	localparam int         TAB_STEP         = 4;

	localparam logic [7:0] CODE_NUL    = 8'd0;
	localparam logic [7:0] CODE_TAB    = 8'd9;
	localparam logic [7:0] CODE_NL     = 8'd10;
	localparam logic [7:0] CODE_PREFIX = 8'd26;
	localparam logic [7:0] CODE_SPACE  = 8'd32;

	// one cell write as it leaves the block
	typedef struct packed {
		logic [4:0] row;
		logic [6:0] column;
		logic [7:0] cell_code;
		logic       last_write;
	} cell_write_t;

	// compare results of the cursor unit
	typedef struct packed {
		logic tab_wraps;
		logic at_width;
		logic fill_done;
	} cursor_flags_t;

endpackage

// ----- src/txw_cursor_alu.sv -----
`timescale 1ns / 1ps

module txw_cursor_alu #(
	parameter int ROW_LENGTH = txw_pkg::ROW_LENGTH_DEF
) (
	input  logic [$clog2(ROW_LENGTH)-1:0] cursor,
	input  logic [$clog2(ROW_LENGTH)-1:0] stop,
	input  logic [6:0]                    wrap_width,
	output logic [$clog2(ROW_LENGTH)-1:0] w_eff,
	output logic [$clog2(ROW_LENGTH)-1:0] cur_inc,
	output logic [$clog2(ROW_LENGTH)-1:0] tab_stop,
	output txw_pkg::cursor_flags_t        flags
);
	import txw_pkg::*;

	localparam int CW = $clog2(ROW_LENGTH);
	localparam logic [8:0] W_MAX = 9'(ROW_LENGTH - 2);
	localparam logic [8:0] W_MIN = 9'(MIN_WIDTH);

	logic [8:0] w9;
	logic [8:0] cur9;
	logic [8:0] stop9;

	// clamp the width so that the newline and terminator cells still fit the row
	always_comb begin
		w9 = {2'b00, wrap_width};
		if (w9 > W_MAX) begin
			w9 = W_MAX;
		end
		if (w9 < W_MIN) begin
			w9 = W_MIN;
		end
	end

	assign cur9     = 9'(cursor);
	assign stop9    = 9'({cursor[CW-1:2], 2'b00}) + 9'(TAB_STEP);
	assign w_eff    = CW'(w9);
	assign cur_inc  = cursor + 1'b1;
	assign tab_stop = CW'(stop9);

	assign flags.tab_wraps = (stop9 >= w9);
	assign flags.at_width  = (cur9 >= w9);
	assign flags.fill_done = (cur_inc == stop);

endmodule

// ----- src/txw_out_reg.sv -----
`timescale 1ns / 1ps

module txw_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  txw_pkg::cell_write_t  item,
	input  logic                  stall,
	output logic                  free,
	output logic                  valid,
	output txw_pkg::cell_write_t  item_q
);
	import txw_pkg::*;

	logic valid_q;

	// slot opens when empty or when the held request is taken this edge
	assign free  = !valid_q || !stall;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			item_q <= item;
		end
	end

endmodule

// ----- src/text_console_wrap_writer.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   char_code
// output    out        out_valid / out_stall row, column, cell_code, last_write
// config    in         wrap_width_we         wrap_width
//
// A character is accepted and then issues 1 to 5 cell writes; a zero byte is
// accepted and writes nothing.
// The sequencer issues at most one write per cycle through the output register.
// Reset clears row and cursor to zero and sets the wrap width to 80.
// out_stall holds the output register and freezes the sequencer; in_stall is
// high while a character is in progress.

module text_console_wrap_writer #(
	parameter int ROW_COUNT  = txw_pkg::ROW_COUNT_DEF,
	parameter int ROW_LENGTH = txw_pkg::ROW_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wrap_width_we,
	input  logic [6:0] wrap_width,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] row,
	output logic [6:0] column,
	output logic [7:0] cell_code,
	output logic       last_write
);
	import txw_pkg::*;

	localparam int RW = $clog2(ROW_COUNT);
	localparam int CW = $clog2(ROW_LENGTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_NL,
		S_TERM,
		S_PREFIX,
		S_SPACE,
		S_CHAR,
		S_FILL
	} state_t;

	typedef enum logic [1:0] {
		K_NL,
		K_TAB,
		K_CHR
	} kind_t;

	state_t        state_q;
	kind_t         kind_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] stop_q;
	logic [7:0]    ch_q;
	logic [6:0]    wrap_width_q;

	logic [CW-1:0] w_eff;
	logic [CW-1:0] cur_inc;
	logic [CW-1:0] tab_stop;
	cursor_flags_t flags;

	logic          slot_free;
	logic          emit;
	cell_write_t   wr;
	cell_write_t   out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= WRAP_WIDTH_RESET;
		end else if (wrap_width_we) begin
			wrap_width_q <= wrap_width;
		end
	end

	txw_cursor_alu #(
		.ROW_LENGTH(ROW_LENGTH)
	) u_alu (
		.cursor    (cursor_q),
		.stop      (stop_q),
		.wrap_width(wrap_width_q),
		.w_eff     (w_eff),
		.cur_inc   (cur_inc),
		.tab_stop  (tab_stop),
		.flags     (flags)
	);

	assign in_stall = (state_q != S_IDLE);
	assign emit     = (state_q != S_IDLE);

	always_comb begin
		wr.row        = 5'(row_q);
		wr.column     = 7'(cursor_q);
		wr.cell_code  = CODE_NUL;
		wr.last_write = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_NL: begin
				wr.cell_code = CODE_NL;
			end
			S_TERM: begin
				wr.cell_code  = CODE_NUL;
				wr.last_write = (kind_q == K_NL);
			end
			S_PREFIX: begin
				wr.cell_code = CODE_PREFIX;
			end
			S_SPACE: begin
				wr.cell_code  = CODE_SPACE;
				wr.last_write = (kind_q == K_TAB);
			end
			S_CHAR: begin
				wr.cell_code  = ch_q;
				wr.last_write = 1'b1;
			end
			S_FILL: begin
				wr.cell_code  = CODE_SPACE;
				wr.last_write = flags.fill_done;
			end
			default: begin
			end
		endcase
	end

	txw_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (emit),
		.item  (wr),
		.stall (out_stall),
		.free  (slot_free),
		.valid (out_valid),
		.item_q(out_q)
	);

	assign row        = out_q.row;
	assign column     = out_q.column;
	assign cell_code  = out_q.cell_code;
	assign last_write = out_q.last_write;

	// character byte and tab stop of the request in progress
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			ch_q   <= char_code;
			stop_q <= tab_stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kind_q   <= K_CHR;
			row_q    <= '0;
			cursor_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						priority if (char_code == CODE_NUL) begin
							state_q <= S_IDLE;
						end else if (char_code == CODE_NL) begin
							kind_q  <= K_NL;
							state_q <= S_NL;
						end else if (char_code == CODE_TAB) begin
							kind_q <= K_TAB;
							if (flags.tab_wraps) begin
								// drop the tab, newline lands at the width
								cursor_q <= w_eff;
								state_q  <= S_NL;
							end else begin
								state_q <= S_FILL;
							end
						end else begin
							kind_q  <= K_CHR;
							state_q <= flags.at_width ? S_NL : S_CHAR;
						end
					end
				end
				S_NL: begin
					if (slot_free) begin
						cursor_q <= cur_inc;
						state_q  <= S_TERM;
					end
				end
				S_TERM: begin
					if (slot_free) begin
						cursor_q <= '0;
						row_q    <= (row_q == RW'(ROW_COUNT - 1)) ? '0 : row_q + 1'b1;
						state_q  <= (kind_q == K_NL) ? S_IDLE : S_PREFIX;
					end
				end
				S_PREFIX: begin
					if (slot_free) begin
						cursor_q <= cur_inc;
						state_q  <= S_SPACE;
					end
				end
				S_SPACE: begin
					if (slot_free) begin
						cursor_q <= cur_inc;
						state_q  <= (kind_q == K_TAB) ? S_IDLE : S_CHAR;
					end
				end
				S_CHAR: begin
					if (slot_free) begin
						cursor_q <= cur_inc;
						state_q  <= S_IDLE;
					end
				end
				S_FILL: begin
					if (slot_free) begin
						cursor_q <= cur_inc;
						if (flags.fill_done) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_below_stop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> cursor_q < stop_q)
		else $error("tab fill ran past its stop");

	a_row_moves_on_term: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(row_q) |-> $past(state_q) == S_TERM && $past(slot_free))
		else $error("row advanced outside a terminator write");

	a_char_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHAR && slot_free |=> out_valid && last_write)
		else $error("character write not flagged last");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && slot_free && wr.last_write |=> state_q == S_IDLE)
		else $error("sequencer busy after last write");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import txw_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 150;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       wrap_width_we = 1'b0;
	logic [6:0] wrap_width    = WRAP_WIDTH_RESET;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [7:0] char_code     = 8'd0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic [4:0] row;
	logic [6:0] column;
	logic [7:0] cell_code;
	logic       last_write;

	text_console_wrap_writer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wrap_width_we(wrap_width_we),
		.wrap_width   (wrap_width),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row          (row),
		.column       (column),
		.cell_code    (cell_code),
		.last_write   (last_write)
	);

	always #5 clk = ~clk;

	// console state as the block should hold it
	logic [6:0] console_wrap = WRAP_WIDTH_RESET;
	logic [4:0] console_row  = 5'd0;
	int         console_col  = 0;

	logic [7:0]  pending_chars[$];
	cell_write_t expected_writes[$];
	cell_write_t want_write;
	int          mismatch_count = 0;

	task automatic put_cell(input logic [7:0] code);
		cell_write_t cw;
		cw.row        = console_row;
		cw.column     = console_col[6:0];
		cw.cell_code  = code;
		cw.last_write = 1'b0;
		expected_writes.push_back(cw);
	endtask

	task automatic close_line();
		put_cell(CODE_NL);
		console_col++;
		put_cell(CODE_NUL);
		console_row = console_row + 5'd1;
		console_col = 0;
	endtask

	task automatic wrap_to_next_line();
		close_line();
		put_cell(CODE_PREFIX);
		console_col++;
		put_cell(CODE_SPACE);
		console_col++;
	endtask

	task automatic place_char(input logic [7:0] ch);
		int          width;
		int          tab_stop;
		int          idx;
		cell_write_t cw;
		width = console_wrap;
		if (width > ROW_LENGTH_DEF - 2)
			width = ROW_LENGTH_DEF - 2;
		if (width < MIN_WIDTH)
			width = MIN_WIDTH;
		if (ch == CODE_NUL)
			return;
		if (ch == CODE_NL) begin
			close_line();
		end else if (ch == CODE_TAB) begin
			tab_stop = TAB_STEP * ((console_col + TAB_STEP) / TAB_STEP);
			if (tab_stop >= width) begin
				// the tab is used up by the wrap; newline lands on the width
				console_col = width;
				wrap_to_next_line();
			end else begin
				while (console_col < tab_stop) begin
					put_cell(CODE_SPACE);
					console_col++;
				end
			end
		end else begin
			if (console_col >= width)
				wrap_to_next_line();
			put_cell(ch);
			console_col++;
		end
		idx = expected_writes.size() - 1;
		cw = expected_writes[idx];
		cw.last_write = 1'b1;
		expected_writes[idx] = cw;
	endtask

	// request sender: bursts of random length, random gaps in between
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				place_char(char_code);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					in_valid  <= 1'b1;
					char_code <= pending_chars.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stall pattern changes per window, plus one long hold
	int          hold_left       = 0;
	int          stall_window    = 0;
	stall_mode_t stall_mode      = STALL_NONE;
	bit          long_hold_armed = 1'b0;

	always @(posedge clk) begin
		if (long_hold_armed) begin
			hold_left       = LONG_HOLD;
			long_hold_armed = 1'b0;
		end
		if (stall_window == 0) begin
			stall_window = $urandom_range(16, 64);
			stall_mode   = stall_mode_t'($urandom_range(0, 3));
		end
		stall_window--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= $urandom_range(0, 1);
				default:     out_stall <= (stall_window % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_writes.size() == 0) begin
				$error("unexpected cell write: row %0d column %0d code %0d",
					row, column, cell_code);
				mismatch_count++;
			end else begin
				want_write = expected_writes.pop_front();
				if (row !== want_write.row) begin
					$error("row: expected %0d, got %0d", want_write.row, row);
					mismatch_count++;
				end
				if (column !== want_write.column) begin
					$error("column: expected %0d, got %0d", want_write.column, column);
					mismatch_count++;
				end
				if (cell_code !== want_write.cell_code) begin
					$error("cell_code: expected %0d, got %0d", want_write.cell_code, cell_code);
					mismatch_count++;
				end
				if (last_write !== want_write.last_write) begin
					$error("last_write: expected %0d, got %0d", want_write.last_write, last_write);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: cycles without any accepted request or result
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_chars.size() > 0 || in_valid || expected_writes.size() > 0)
			@(posedge clk);
		// a zero byte may still be in flight with nothing expected
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_wrap(input logic [6:0] value);
		wait_drained();
		wrap_width_we <= 1'b1;
		wrap_width    <= value;
		console_wrap = value;
		@(posedge clk);
		wrap_width_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back(s[i]);
	endtask

	function automatic logic [7:0] random_char(input int nl_weight, input int tab_weight);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < nl_weight)
			return CODE_NL;
		if (pick < nl_weight + tab_weight)
			return CODE_TAB;
		if (pick < nl_weight + tab_weight + 4)
			return CODE_NUL;
		if (pick < nl_weight + tab_weight + 20)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(33, 126));
	endfunction

	task automatic random_phase(input logic [6:0] wrap_value, input int count,
		input int nl_weight, input int tab_weight, input bit with_hold);
		set_wrap(wrap_value);
		for (int i = 0; i < count; i++)
			pending_chars.push_back(random_char(nl_weight, tab_weight));
		// hold off results while the sender keeps offering
		if (with_hold)
			long_hold_armed = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default width: byte extremes, ignored zero, tab fill, newlines
		pending_chars.push_back("A");
		pending_chars.push_back(8'hFF);
		pending_chars.push_back(CODE_NUL);
		pending_chars.push_back(8'h01);
		pending_chars.push_back(CODE_TAB);
		pending_chars.push_back(CODE_TAB);
		pending_chars.push_back(CODE_NL);
		pending_chars.push_back(CODE_NL);

		// width below the minimum acts as 4: tab wrap, then wrap on a character
		set_wrap(7'd0);
		queue_text("abc\txxx");

		// width above the limit clamps; then shrink under the cursor
		set_wrap(7'd127);
		queue_text("abcdef");
		set_wrap(7'd3);
		queue_text("b");
		set_wrap(7'd127);
		queue_text("zzzz");
		set_wrap(7'd4);
		pending_chars.push_back(CODE_TAB);

		random_phase(7'($urandom_range(4, 12)), 20, 10, 20, 1'b0);
		random_phase(WRAP_WIDTH_RESET, 15, 8, 20, 1'b1);
		random_phase(7'($urandom_range(0, 127)), 15, 8, 20, 1'b0);
		random_phase(7'd126, 45, 0, 30, 1'b0);

		wait_drained();
		if (expected_writes.size() != 0) begin
			$error("%0d cell writes never arrived", expected_writes.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/txw_pkg.sv
src/txw_cursor_alu.sv
src/txw_out_reg.sv
src/text_console_wrap_writer.sv
sim/tb.sv
